// ===== hdl/differential_drive_odometry_core_assert.svh =====
// Assertion macros used by the odometry core file.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// checked only out of reset
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/ddo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and tables of the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int MUL_A_W = 73;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = 106;

    localparam logic [7:0] CFG_TICK_SCALE    = 8'd0;
    localparam logic [7:0] CFG_INV_WHEELBASE = 8'd1;

    localparam logic [39:0] TICK_SCALE_RST    = 40'd650908838;
    localparam logic [31:0] INV_WHEELBASE_RST = 32'd33554432;
    localparam logic [32:0] INV_TWO_PI        = 33'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_RAD1, S_RAD2, S_TURN, S_CORD, S_DX, S_DY, S_FIN
    } t_state;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_P_W-1:0] product;
    } t_mul_rsp;

endpackage

// ===== hdl/differential_drive_odometry_core.sv =====
`timescale 1ns / 1ps
`include "differential_drive_odometry_core_assert.svh"
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry: absolute encoder counts in, pose and step motion out.
//
// Input word: left and right absolute counts, valid/ready. Output word: pose
// x/y (Q16.16, saturating), heading (binary angle), step distance and turn,
// valid/ready. The config port writes tick scale (index 0) and reciprocal
// wheel base (index 1); other indexes are ignored.
// One word is processed at a time. A serial shift-add multiplier (one bit
// per cycle) runs six products in sequence and an iterative CORDIC runs
// CORDIC_STEPS rotations; the multiplier stops early, so a word finishes
// sooner when count deltas are small.
// The result sits in an output register: the next input word is accepted
// while it waits, and the pose update of that word holds until the earlier
// result has been taken. Reset clears pose and previous counts to zero and
// loads the default register values.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_index,
    input  logic [39:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [31:0]        o_heading,
    output logic signed [31:0] o_step_distance,
    output logic signed [31:0] o_step_turn
);

    t_state r_state, n_state;
    logic   r_launched, n_launched;

    logic [39:0]        r_tick_scale;
    logic [31:0]        r_inv_wb;
    logic [31:0]        r_prev_left;
    logic [31:0]        r_prev_right;
    logic signed [31:0] r_pose_x;
    logic signed [31:0] r_pose_y;
    logic [31:0]        r_heading;
    logic               r_out_valid;
    logic signed [31:0] r_out_dist;
    logic [31:0]        r_out_turn;

    logic signed [32:0] r_sum;
    logic signed [32:0] r_diff;
    logic signed [31:0] r_dist;
    logic [MUL_A_W-1:0] r_p;
    logic [31:0]        r_turn;
    logic signed [33:0] r_cs;
    logic signed [33:0] r_sn;
    logic signed [36:0] r_dx;
    logic signed [36:0] r_dy;

    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;
    logic               cor_start;
    logic               cor_done;
    logic signed [33:0] cor_cos;
    logic signed [33:0] cor_sin;

    logic               in_acc;
    logic               fin_load;
    logic [31:0]        dl;
    logic [31:0]        dr;
    logic [32:0]        mag_sum;
    logic [32:0]        mag_diff;
    logic [31:0]        mag_dist;
    logic [33:0]        mag_cs;
    logic [33:0]        mag_sn;
    logic [MUL_P_W-1:0] prod_rnd;
    logic [40:0]        dist_v;
    logic signed [31:0] dist_sat;
    logic [31:0]        turn_mag;
    logic [31:0]        mid_angle;
    logic               prod_neg;
    logic signed [66:0] prod_s;
    logic signed [66:0] prod_r;
    logic signed [37:0] sum_x;
    logic signed [37:0] sum_y;
    logic signed [31:0] sat_x;
    logic signed [31:0] sat_y;

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (mid_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign fin_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    assign dl       = i_left_count - r_prev_left;
    assign dr       = i_right_count - r_prev_right;
    assign mag_sum  = r_sum[32] ? 33'(-r_sum) : 33'(r_sum);
    assign mag_diff = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
    assign mag_dist = r_dist[31] ? 32'(-r_dist) : 32'(r_dist);
    assign mag_cs   = r_cs[33] ? 34'(-r_cs) : 34'(r_cs);
    assign mag_sn   = r_sn[33] ? 34'(-r_sn) : 34'(r_sn);
    assign mid_angle = r_heading + {r_turn[31], r_turn[31:1]};

    // rounding bias per product, picked by state
    always_comb begin
        unique case (r_state)
            S_DIST:  prod_rnd = mul_rsp.product + (MUL_P_W'(1) << 32);
            S_RAD2:  prod_rnd = mul_rsp.product + (MUL_P_W'(1) << 39);
            S_TURN:  prod_rnd = mul_rsp.product + (MUL_P_W'(1) << 31);
            default: prod_rnd = mul_rsp.product;
        endcase
    end

    assign dist_v   = prod_rnd[73:33];
    assign turn_mag = prod_rnd[63:32];

    always_comb begin
        if (r_sum[32]) begin
            dist_sat = (dist_v > 41'h0_8000_0000) ? 32'sh8000_0000 : 32'(-dist_v);
        end else begin
            dist_sat = (dist_v > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(dist_v);
        end
    end

    assign prod_neg = (r_state == S_DX) ? (r_dist[31] ^ r_cs[33]) : (r_dist[31] ^ r_sn[33]);
    assign prod_s   = prod_neg ? -$signed({1'b0, mul_rsp.product[65:0]})
                               : $signed({1'b0, mul_rsp.product[65:0]});
    assign prod_r   = prod_s + 67'sd536870912;

    assign sum_x = 38'(r_pose_x) + 38'(r_dx);
    assign sum_y = 38'(r_pose_y) + 38'(r_dy);

    always_comb begin
        if (sum_x > 38'sh0_7FFF_FFFF) begin
            sat_x = 32'sh7FFF_FFFF;
        end else if (sum_x < -38'sh0_8000_0000) begin
            sat_x = 32'sh8000_0000;
        end else begin
            sat_x = 32'(sum_x);
        end
        if (sum_y > 38'sh0_7FFF_FFFF) begin
            sat_y = 32'sh7FFF_FFFF;
        end else if (sum_y < -38'sh0_8000_0000) begin
            sat_y = 32'sh8000_0000;
        end else begin
            sat_y = 32'(sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_launched  = r_launched;
        mul_req     = '0;
        cor_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                mul_req.a = MUL_A_W'(r_tick_scale);
                mul_req.b = mag_sum;
            end
            S_RAD1: begin
                mul_req.a = MUL_A_W'(r_tick_scale);
                mul_req.b = mag_diff;
            end
            S_RAD2: begin
                mul_req.a = r_p;
                mul_req.b = MUL_B_W'(r_inv_wb);
            end
            S_TURN: begin
                mul_req.a = r_p;
                mul_req.b = INV_TWO_PI;
            end
            S_CORD: begin
                cor_start = !r_launched;
            end
            S_DX: begin
                mul_req.a = MUL_A_W'(mag_cs);
                mul_req.b = MUL_B_W'(mag_dist);
            end
            S_DY: begin
                mul_req.a = MUL_A_W'(mag_sn);
                mul_req.b = MUL_B_W'(mag_dist);
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_DIST || r_state == S_RAD1 || r_state == S_RAD2 ||
            r_state == S_TURN || r_state == S_DX || r_state == S_DY) begin
            mul_req.start = !r_launched;
            if (mul_rsp.done && r_launched) begin
                n_state = (r_state == S_DIST) ? S_RAD1 :
                          (r_state == S_RAD1) ? S_RAD2 :
                          (r_state == S_RAD2) ? S_TURN :
                          (r_state == S_TURN) ? S_CORD :
                          (r_state == S_DX)   ? S_DY : S_FIN;
            end
        end
        if (r_state == S_CORD && cor_done && r_launched) begin
            n_state = S_DX;
        end
        if (mul_req.start || cor_start) begin
            n_launched = 1'b1;
        end
        if (n_state != r_state) begin
            n_launched = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_scale <= TICK_SCALE_RST;
            r_inv_wb     <= INV_WHEELBASE_RST;
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_pose_x     <= '0;
            r_pose_y     <= '0;
            r_heading    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index == CFG_TICK_SCALE) begin
                r_tick_scale <= i_cfg_wdata;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_INV_WHEELBASE) begin
                r_inv_wb <= i_cfg_wdata[31:0];
            end
            if (in_acc) begin
                r_prev_left  <= i_left_count;
                r_prev_right <= i_right_count;
            end
            if (fin_load) begin
                r_pose_x    <= sat_x;
                r_pose_y    <= sat_y;
                r_heading   <= r_heading + r_turn;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum  <= 33'(signed'(dl)) + 33'(signed'(dr));
            r_diff <= 33'(signed'(dr)) - 33'(signed'(dl));
        end
        if (mul_rsp.done && r_launched) begin
            unique case (r_state)
                S_DIST:  r_dist <= dist_sat;
                S_RAD1:  r_p    <= mul_rsp.product[MUL_A_W-1:0];
                S_RAD2:  r_p    <= MUL_A_W'(prod_rnd[103:40]);
                S_TURN:  r_turn <= r_diff[32] ? (32'd0 - turn_mag) : turn_mag;
                S_DX:    r_dx   <= prod_r[66:30];
                S_DY:    r_dy   <= prod_r[66:30];
                default: ;
            endcase
        end
        if (r_state == S_CORD && cor_done && r_launched) begin
            r_cs <= cor_cos;
            r_sn <= cor_sin;
        end
        if (fin_load) begin
            r_out_dist <= r_dist;
            r_out_turn <= r_turn;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_pose_x;
    assign o_pos_y         = r_pose_y;
    assign o_heading       = r_heading;
    assign o_step_distance = r_out_dist;
    assign o_step_turn     = r_out_turn;

    `DDO_ASSERT(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready after accept")
    `DDO_ASSERT(a_mul_start_idle, mul_req.start |-> !mul_rsp.busy, "multiplier restarted while busy")
    `DDO_ASSERT(a_heading_step, fin_load |=> r_heading == $past(r_heading + r_turn), "heading step")
    `DDO_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid && o_in_ready, "reset state")

endmodule

// ===== hdl/ddo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_mul
// Serial shift-add multiplier, one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module ddo_mul
    import ddo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic               r_busy;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= MUL_P_W'(i_req.a);
            r_b   <= i_req.b;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_busy && (r_b == '0);
    assign o_rsp.product = r_acc;

endmodule

// ===== hdl/ddo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, Q4.30 cosine and sine of a binary angle,
// one micro-rotation per cycle after quadrant reduction.
// ----------------------------------------------------------------------------
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         r_quad;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [1:0]         quad0;
    logic [31:0]        z0;
    logic [4:0]         idx;
    logic signed [33:0] atan_s;

    assign quad0  = 2'((i_angle + 32'h2000_0000) >> 30);
    assign z0     = i_angle - {quad0, 30'd0};
    assign idx    = 5'(r_cnt);
    assign atan_s = $signed({2'b00, ATAN_TAB[idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_quad <= quad0;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= 34'(signed'(z0));
        end else if (r_busy && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
            if (!r_z[33]) begin
                r_x <= r_x - (r_y >>> idx);
                r_y <= r_y + (r_x >>> idx);
                r_z <= r_z - atan_s;
            end else begin
                r_x <= r_x + (r_y >>> idx);
                r_y <= r_y - (r_x >>> idx);
                r_z <= r_z + atan_s;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(STEPS));

    always_comb begin
        unique case (r_quad)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

endmodule
